// ===== design/atcse_pkg.sv =====
`timescale 1ns / 1ps
package atcse_pkg;

	localparam int unsigned LINE_MAX_DEF = 32;
	localparam int unsigned LEN_W = 6;
	localparam int unsigned TICK_W = 24;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
	localparam logic [7:0] CMD_CHAR_RST = 8'd43;
	localparam logic [TICK_W-1:0] GUARD_RST = 24'd1000;
	localparam logic [TICK_W-1:0] OK_WAIT_RST = 24'd1000;
	localparam logic [TICK_W-1:0] SESSION_RST = 24'd10000;
	localparam logic [TICK_W-1:0] EXIT_WAIT_RST = 24'd1000;

	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_O = 8'h4F;
	localparam logic [7:0] CH_K = 8'h4B;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CMD_CHAR  = 3'd0,
		REG_GUARD     = 3'd1,
		REG_OK_WAIT   = 3'd2,
		REG_SESSION   = 3'd3,
		REG_EXIT_WAIT = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_RX      = 3'd0,
		OP_TICK    = 3'd1,
		OP_ENTER   = 3'd2,
		OP_SEND    = 3'd3,
		OP_EXIT    = 3'd4,
		OP_ABANDON = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_GUARD   = 3'd1,
		ST_WAITOK  = 3'd2,
		ST_ACTIVE  = 3'd3,
		ST_BUSY    = 3'd4,
		ST_EXITING = 3'd5
	} sess_t;

	localparam logic [2:0] K_TX = 3'd0;
	localparam logic [2:0] K_DATA = 3'd1;
	localparam logic [2:0] K_LINE = 3'd2;
	localparam logic [2:0] K_DONE = 3'd3;
	localparam logic [2:0] K_OPST = 3'd4;

	localparam logic [2:0] LC_EMPTY = 3'd0;
	localparam logic [2:0] LC_OK = 3'd1;
	localparam logic [2:0] LC_ERROR = 3'd2;
	localparam logic [2:0] LC_FSERR = 3'd3;
	localparam logic [2:0] LC_VALUE = 3'd4;

	localparam logic [2:0] S_OK = 3'd0;
	localparam logic [2:0] S_FAIL = 3'd1;
	localparam logic [2:0] S_NOTSUP = 3'd2;
	localparam logic [2:0] S_TIMEOUT = 3'd3;
	localparam logic [2:0] S_ABORT = 3'd4;
	localparam logic [2:0] S_INVALID = 3'd5;

	typedef enum logic [1:0] {
		TX_NONE = 2'd0,
		TX_ESC  = 2'd1,
		TX_CMD  = 2'd2
	} tx_mode_t;

	typedef enum logic [2:0] {
		P_IDLE = 3'd0,
		P_TX   = 3'd1,
		P_RD   = 3'd2,
		P_FIN  = 3'd3,
		P_OPS  = 3'd4,
		P_DAT  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  rx_data;
		logic [15:0] command_code;
		logic        multiline;
		logic [23:0] timeout_ticks;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] byte_value;
		logic [2:0] line_class;
		logic [2:0] status;
		logic [7:0] line_total;
		logic       last;
	} out_item_t;

	typedef struct packed {
		tx_mode_t         tx_mode;
		logic [7:0]       tx_b;
		logic [7:0]       tx_hi;
		logic [7:0]       tx_lo;
		logic [LEN_W-1:0] rd_len;
		logic [2:0]       rd_cls;
		logic             fin;
		logic [2:0]       fin_st;
		logic [2:0]       fin_cls;
		logic [7:0]       fin_cnt;
		logic             ops;
		logic [2:0]       ops_st;
		logic             dat;
		logic [7:0]       dat_b;
	} job_t;

	typedef struct packed {
		logic [LEN_W-1:0] addr;
		logic             done;
	} rd_req_t;

	function automatic logic [7:0] err_char(input logic [LEN_W-1:0] p);
		logic [7:0] c;
		unique case (p)
			6'd0: c = CH_E;
			6'd1: c = CH_R;
			6'd2: c = CH_R;
			6'd3: c = CH_O;
			6'd4: c = CH_R;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
	endfunction

	// First phase after p that the job actually needs; P_IDLE when none is left.
	function automatic phase_t next_phase(input job_t j, input phase_t p);
		phase_t n;
		n = P_IDLE;
		if (p < P_TX && j.tx_mode != TX_NONE) n = P_TX;
		else if (p < P_RD && j.rd_len != '0) n = P_RD;
		else if (p < P_FIN && j.fin) n = P_FIN;
		else if (p < P_OPS && j.ops) n = P_OPS;
		else if (p < P_DAT && j.dat) n = P_DAT;
		return n;
	endfunction

endpackage

// ===== design/atcse_queue.sv =====
`timescale 1ns / 1ps
module atcse_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  atcse_pkg::job_t  push_job,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output atcse_pkg::job_t  head
);
	localparam int unsigned PW = $clog2(atcse_pkg::QUEUE_DEPTH);

	atcse_pkg::job_t slot_q [atcse_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(atcse_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule

// ===== design/atcse_front.sv =====
`timescale 1ns / 1ps
module atcse_front #(
	parameter int unsigned LINE_MAX = atcse_pkg::LINE_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  atcse_pkg::in_item_t                 in_item,
	input  logic                                cfg_wr_en,
	input  logic [atcse_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [atcse_pkg::TICK_W-1:0]        cfg_data,
	input  logic                                q_full,
	output logic                                q_push,
	output atcse_pkg::job_t                     q_job,
	input  atcse_pkg::rd_req_t                  rd_req,
	output logic [7:0]                          rd_data
);
	localparam int unsigned AW = $clog2(LINE_MAX);
	localparam int unsigned LW = atcse_pkg::LEN_W;
	localparam int unsigned TW = atcse_pkg::TICK_W;

	logic [7:0] store [LINE_MAX];
	logic [7:0] rd_data_q;

	logic [7:0]    cmd_char_q;
	logic [TW-1:0] guard_q, ok_wait_q, session_q, exit_wait_q;

	atcse_pkg::sess_t st_q, st_n;
	logic [TW-1:0] stc_q, stc_n, sesc_q, sesc_n, reqc_q, reqc_n, sil_q, sil_n;
	logic [LW-1:0] len_q, len_n;
	logic ovf_q, ovf_n, ract_q, ract_n, rmul_q, rmul_n;
	logic [7:0] rl_q, rl_n;
	// Running classification of the line being assembled.
	logic okm_q, okm_n, erm_q, erm_n, e0_q, e0_n, ef_q, ef_n, efs_q, efs_n;
	logic rd_busy_q;

	logic accept, wr_en, do_clear;
	logic [2:0] cls;
	atcse_pkg::job_t job;

	assign in_ready = !q_full && !rd_busy_q;
	assign accept = in_valid && in_ready;
	assign rd_data = rd_data_q;

	always_comb begin
		if (len_q == '0) cls = atcse_pkg::LC_EMPTY;
		else if (len_q == LW'(2) && okm_q) cls = atcse_pkg::LC_OK;
		else if (len_q == LW'(5) && erm_q) cls = atcse_pkg::LC_ERROR;
		else if (e0_q && ef_q && efs_q) cls = atcse_pkg::LC_FSERR;
		else cls = atcse_pkg::LC_VALUE;
	end

	always_comb begin
		st_n = st_q; stc_n = stc_q; sesc_n = sesc_q; reqc_n = reqc_q; sil_n = sil_q;
		len_n = len_q; ovf_n = ovf_q; ract_n = ract_q; rmul_n = rmul_q; rl_n = rl_q;
		okm_n = okm_q; erm_n = erm_q; e0_n = e0_q; ef_n = ef_q; efs_n = efs_q;
		wr_en = 1'b0;
		do_clear = 1'b0;
		job = '0;
		job.tx_mode = atcse_pkg::TX_NONE;
		if (accept) begin
			unique case (in_item.op)
				atcse_pkg::OP_RX: begin
					if (st_q == atcse_pkg::ST_IDLE) begin
						job.dat = 1'b1;
						job.dat_b = in_item.rx_data;
					end else if (in_item.rx_data == atcse_pkg::CH_LF) begin
						job.dat = 1'b0;
					end else if (in_item.rx_data == atcse_pkg::CH_CR) begin
						if (!ovf_q) begin
							unique case (st_q)
								atcse_pkg::ST_WAITOK: begin
									if (cls == atcse_pkg::LC_OK) begin
										st_n = atcse_pkg::ST_ACTIVE;
										sesc_n = session_q;
									end
								end
								atcse_pkg::ST_EXITING: begin
									if (cls == atcse_pkg::LC_OK) begin
										st_n = atcse_pkg::ST_IDLE;
										if (ract_q) begin
											job.fin = 1'b1;
											job.fin_st = atcse_pkg::S_OK;
											job.fin_cls = cls;
											job.fin_cnt = rl_q;
											ract_n = 1'b0;
										end
									end
								end
								atcse_pkg::ST_BUSY: begin
									if (ract_q) begin
										if (!(cls == atcse_pkg::LC_EMPTY && !rmul_q)
												&& rl_q != 8'hFF)
											rl_n = rl_q + 8'd1;
										sesc_n = session_q;
										if (cls == atcse_pkg::LC_VALUE || cls == atcse_pkg::LC_FSERR)
										begin
											job.rd_len = len_q;
											job.rd_cls = cls;
										end
										job.fin_cnt = rl_n;
										job.fin_cls = cls;
										if (rmul_q) begin
											if (cls == atcse_pkg::LC_EMPTY) begin
												st_n = atcse_pkg::ST_ACTIVE;
												job.fin = 1'b1;
												job.fin_st = atcse_pkg::S_OK;
												ract_n = 1'b0;
											end
										end else if (cls != atcse_pkg::LC_EMPTY) begin
											st_n = atcse_pkg::ST_ACTIVE;
											job.fin = 1'b1;
											job.fin_st = (cls == atcse_pkg::LC_ERROR) ?
												atcse_pkg::S_FAIL :
												(cls == atcse_pkg::LC_FSERR) ?
												atcse_pkg::S_NOTSUP : atcse_pkg::S_OK;
											ract_n = 1'b0;
										end
									end
								end
								default: begin
									st_n = st_q;
								end
							endcase
						end
						do_clear = 1'b1;
					end else if (len_q >= LW'(LINE_MAX)) begin
						ovf_n = 1'b1;
					end else begin
						wr_en = 1'b1;
						len_n = len_q + 1'b1;
						if (len_q == LW'(0)) begin
							okm_n = okm_q && in_item.rx_data == atcse_pkg::CH_O;
							e0_n = in_item.rx_data == atcse_pkg::CH_E;
						end else if (len_q == LW'(1)) begin
							okm_n = okm_q && in_item.rx_data == atcse_pkg::CH_K;
						end
						if (len_q < LW'(5))
							erm_n = erm_q && in_item.rx_data == atcse_pkg::err_char(len_q);
						if (len_q != '0 && !ef_q && !atcse_pkg::is_alnum(in_item.rx_data)) begin
							ef_n = 1'b1;
							efs_n = in_item.rx_data == atcse_pkg::CH_SP && len_q > LW'(1);
						end
					end
				end
				atcse_pkg::OP_TICK: begin
					if (sil_q != atcse_pkg::TICK_MAX) sil_n = sil_q + 1'b1;
					if (stc_q != '0) stc_n = stc_q - 1'b1;
					if (sesc_q != '0) sesc_n = sesc_q - 1'b1;
					if (reqc_q != '0) reqc_n = reqc_q - 1'b1;
					unique case (st_q)
						atcse_pkg::ST_GUARD: begin
							if (sil_n >= guard_q) begin
								job.tx_mode = atcse_pkg::TX_ESC;
								job.tx_b = cmd_char_q;
								sil_n = '0;
								st_n = atcse_pkg::ST_WAITOK;
								stc_n = ok_wait_q;
								do_clear = 1'b1;
							end
						end
						atcse_pkg::ST_WAITOK: begin
							if (stc_n == '0) begin
								st_n = atcse_pkg::ST_IDLE;
								do_clear = 1'b1;
							end
						end
						atcse_pkg::ST_BUSY: begin
							if (reqc_n == '0) begin
								st_n = atcse_pkg::ST_ACTIVE;
								if (ract_q) begin
									job.fin = 1'b1;
									job.fin_st = (rmul_q && rl_q != '0) ?
										atcse_pkg::S_OK : atcse_pkg::S_TIMEOUT;
									job.fin_cls = atcse_pkg::LC_EMPTY;
									job.fin_cnt = rl_q;
									ract_n = 1'b0;
								end
							end
						end
						atcse_pkg::ST_EXITING: begin
							if (stc_n == '0) begin
								st_n = atcse_pkg::ST_IDLE;
								if (ract_q) begin
									job.fin = 1'b1;
									job.fin_st = atcse_pkg::S_TIMEOUT;
									job.fin_cls = atcse_pkg::LC_EMPTY;
									job.fin_cnt = rl_q;
									ract_n = 1'b0;
								end
								do_clear = 1'b1;
							end
						end
						atcse_pkg::ST_ACTIVE: begin
							if (sesc_n == '0) begin
								st_n = atcse_pkg::ST_IDLE;
								do_clear = 1'b1;
							end
						end
						default: begin
							st_n = st_q;
						end
					endcase
				end
				atcse_pkg::OP_ENTER: begin
					job.ops = 1'b1;
					if (st_q != atcse_pkg::ST_IDLE) begin
						job.ops_st = atcse_pkg::S_INVALID;
					end else begin
						job.ops_st = atcse_pkg::S_OK;
						do_clear = 1'b1;
						st_n = atcse_pkg::ST_GUARD;
					end
				end
				atcse_pkg::OP_SEND: begin
					job.ops = 1'b1;
					if (st_q != atcse_pkg::ST_ACTIVE) begin
						job.ops_st = atcse_pkg::S_INVALID;
					end else begin
						job.ops_st = atcse_pkg::S_OK;
						job.tx_mode = atcse_pkg::TX_CMD;
						job.tx_hi = in_item.command_code[15:8];
						job.tx_lo = in_item.command_code[7:0];
						sil_n = '0;
						ract_n = 1'b1;
						rmul_n = in_item.multiline;
						rl_n = '0;
						reqc_n = in_item.timeout_ticks;
						st_n = atcse_pkg::ST_BUSY;
						do_clear = 1'b1;
					end
				end
				atcse_pkg::OP_EXIT: begin
					job.ops = 1'b1;
					if (st_q != atcse_pkg::ST_ACTIVE && st_q != atcse_pkg::ST_BUSY) begin
						job.ops_st = atcse_pkg::S_INVALID;
					end else begin
						job.ops_st = atcse_pkg::S_OK;
						job.tx_mode = atcse_pkg::TX_CMD;
						job.tx_hi = atcse_pkg::CH_C;
						job.tx_lo = atcse_pkg::CH_N;
						sil_n = '0;
						job.fin = ract_q;
						job.fin_st = atcse_pkg::S_ABORT;
						job.fin_cls = atcse_pkg::LC_EMPTY;
						job.fin_cnt = rl_q;
						ract_n = 1'b1;
						rmul_n = 1'b0;
						rl_n = '0;
						st_n = atcse_pkg::ST_EXITING;
						stc_n = exit_wait_q;
						do_clear = 1'b1;
					end
				end
				atcse_pkg::OP_ABANDON: begin
					job.fin = ract_q;
					job.fin_st = atcse_pkg::S_ABORT;
					job.fin_cls = atcse_pkg::LC_EMPTY;
					job.fin_cnt = rl_q;
					ract_n = 1'b0;
					st_n = atcse_pkg::ST_IDLE;
					do_clear = 1'b1;
					job.ops = 1'b1;
					job.ops_st = atcse_pkg::S_OK;
				end
				default: begin
					job.ops = 1'b0;
				end
			endcase
		end
		if (do_clear) begin
			len_n = '0; ovf_n = 1'b0;
			okm_n = 1'b1; erm_n = 1'b1; e0_n = 1'b0; ef_n = 1'b0; efs_n = 1'b0;
		end
	end

	assign q_job = job;
	assign q_push = accept && (job.tx_mode != atcse_pkg::TX_NONE || job.rd_len != '0 ||
		job.fin || job.ops || job.dat);

	always_ff @(posedge clk) begin
		if (wr_en) store[len_q[AW-1:0]] <= in_item.rx_data;
		rd_data_q <= store[rd_req.addr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_char_q <= atcse_pkg::CMD_CHAR_RST;
			guard_q <= atcse_pkg::GUARD_RST;
			ok_wait_q <= atcse_pkg::OK_WAIT_RST;
			session_q <= atcse_pkg::SESSION_RST;
			exit_wait_q <= atcse_pkg::EXIT_WAIT_RST;
			st_q <= atcse_pkg::ST_IDLE;
			stc_q <= '0; sesc_q <= '0; reqc_q <= '0;
			sil_q <= atcse_pkg::TICK_MAX;
			len_q <= '0; ovf_q <= 1'b0; ract_q <= 1'b0; rmul_q <= 1'b0; rl_q <= '0;
			okm_q <= 1'b1; erm_q <= 1'b1; e0_q <= 1'b0; ef_q <= 1'b0; efs_q <= 1'b0;
			rd_busy_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					atcse_pkg::REG_CMD_CHAR: cmd_char_q <= cfg_data[7:0];
					atcse_pkg::REG_GUARD: guard_q <= cfg_data;
					atcse_pkg::REG_OK_WAIT: ok_wait_q <= cfg_data;
					atcse_pkg::REG_SESSION: session_q <= cfg_data;
					atcse_pkg::REG_EXIT_WAIT: exit_wait_q <= cfg_data;
					default: cmd_char_q <= cmd_char_q;
				endcase
			end
			st_q <= st_n; stc_q <= stc_n; sesc_q <= sesc_n; reqc_q <= reqc_n; sil_q <= sil_n;
			len_q <= len_n; ovf_q <= ovf_n; ract_q <= ract_n; rmul_q <= rmul_n; rl_q <= rl_n;
			okm_q <= okm_n; erm_q <= erm_n; e0_q <= e0_n; ef_q <= ef_n; efs_q <= efs_n;
			// The line store must hold still until the back end has read the line out.
			if (q_push && job.rd_len != '0) rd_busy_q <= 1'b1;
			else if (rd_req.done) rd_busy_q <= 1'b0;
		end
	end
endmodule

// ===== design/atcse_back.sv =====
`timescale 1ns / 1ps
module atcse_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  atcse_pkg::job_t        head,
	output logic                   q_pop,
	output atcse_pkg::rd_req_t     rd_req,
	input  logic [7:0]             rd_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output atcse_pkg::out_item_t   out_item
);
	localparam int unsigned LW = atcse_pkg::LEN_W;

	atcse_pkg::phase_t ph_q, ph_n, nxt;
	logic [LW-1:0] idx_q;
	logic dv_q, fire, seg_end;
	atcse_pkg::out_item_t res;

	assign nxt = atcse_pkg::next_phase(head, ph_q);

	always_comb begin
		res = '0;
		seg_end = 1'b1;
		unique case (ph_q)
			atcse_pkg::P_TX: begin
				res.kind = atcse_pkg::K_TX;
				if (head.tx_mode == atcse_pkg::TX_ESC) begin
					res.byte_value = head.tx_b;
					seg_end = (idx_q == LW'(2));
				end else begin
					unique case (idx_q)
						6'd0: res.byte_value = atcse_pkg::CH_A;
						6'd1: res.byte_value = atcse_pkg::CH_T;
						6'd2: res.byte_value = head.tx_hi;
						6'd3: res.byte_value = head.tx_lo;
						default: res.byte_value = atcse_pkg::CH_CR;
					endcase
					seg_end = (idx_q == LW'(4));
				end
			end
			atcse_pkg::P_RD: begin
				res.kind = atcse_pkg::K_LINE;
				res.byte_value = rd_data;
				res.line_class = head.rd_cls;
				seg_end = (idx_q == head.rd_len - 1'b1);
			end
			atcse_pkg::P_FIN: begin
				res.kind = atcse_pkg::K_DONE;
				res.line_class = head.fin_cls;
				res.status = head.fin_st;
				res.line_total = head.fin_cnt;
			end
			atcse_pkg::P_OPS: begin
				res.kind = atcse_pkg::K_OPST;
				res.status = head.ops_st;
			end
			atcse_pkg::P_DAT: begin
				res.kind = atcse_pkg::K_DATA;
				res.byte_value = head.dat_b;
			end
			default: begin
				res = '0;
			end
		endcase
		res.last = seg_end && nxt == atcse_pkg::P_IDLE;
	end

	assign out_item = res;
	assign out_valid = ph_q != atcse_pkg::P_IDLE && (ph_q != atcse_pkg::P_RD || dv_q);
	assign fire = out_valid && out_ready;
	assign q_pop = fire && seg_end && nxt == atcse_pkg::P_IDLE;
	assign rd_req.addr = idx_q;
	assign rd_req.done = fire && ph_q == atcse_pkg::P_RD && seg_end;

	always_comb begin
		ph_n = ph_q;
		if (ph_q == atcse_pkg::P_IDLE) begin
			if (!q_empty) ph_n = nxt;
		end else if (fire && seg_end) begin
			ph_n = nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= atcse_pkg::P_IDLE;
			idx_q <= '0;
			dv_q <= 1'b0;
		end else begin
			ph_q <= ph_n;
			if (fire) idx_q <= seg_end ? '0 : idx_q + 1'b1;
			// Read data is registered, so it is good in the cycle after the address settles.
			dv_q <= ph_q == atcse_pkg::P_RD && !fire;
		end
	end
endmodule

// ===== design/at_command_session_engine.sv =====
`timescale 1ns / 1ps
// Command-mode session engine for a serial modem link.
// Input items (in_valid/in_ready, in_item) carry received bytes, ticks and
// host events; result items leave on out_valid/out_ready as out_item, and
// the last result caused by an input item has its last bit set.
// Registers are written through cfg_wr_en, cfg_index and cfg_data, one per
// cycle, without handshake.
// The front end turns an accepted input item into a job descriptor; a
// two-entry job queue feeds the back end, which, when idle, registers its
// phase from the queue head before offering a job's first result. It then
// sends one result per cycle while out_ready is high, except reply-line bytes,
// each of which waits for a read of the line store through a registered port,
// and it returns to its idle phase between jobs.
// While a reply line waits to be read out, or both queue entries are taken,
// in_ready is low, so a stalled receiver holds back the input side as soon as
// two jobs are waiting.
// Reset restores the register defaults, returns the session to idle with a
// saturated silence count, and empties the queue. The line store is not
// cleared.
module at_command_session_engine #(
	parameter int unsigned LINE_MAX = atcse_pkg::LINE_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  atcse_pkg::in_item_t             in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output atcse_pkg::out_item_t            out_item,
	input  logic                            cfg_wr_en,
	input  logic [atcse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [atcse_pkg::TICK_W-1:0]    cfg_data
);
	logic q_full, q_empty, q_push, q_pop;
	atcse_pkg::job_t push_job, head;
	atcse_pkg::rd_req_t rd_req;
	logic [7:0] rd_data;

	atcse_front #(.LINE_MAX(LINE_MAX)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.q_full(q_full), .q_push(q_push), .q_job(push_job),
		.rd_req(rd_req), .rd_data(rd_data)
	);

	atcse_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_job(push_job), .pop(q_pop),
		.full(q_full), .empty(q_empty), .head(head)
	);

	atcse_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .head(head), .q_pop(q_pop),
		.rd_req(rd_req), .rd_data(rd_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);
endmodule
